@@ sv/http_body_deframer_assert.svh @@
// assertion macros for the body deframer
`ifndef HTTP_BODY_DEFRAMER_ASSERT_SVH
`define HTTP_BODY_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("http_body_deframer assertion failed");
`define HBD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("http_body_deframer reset assertion failed");
`else
`define HBD_ASSERT(lbl, prop)
`define HBD_ASSERT_RST(lbl, prop)
`endif

`endif

@@ sv/hbd_pkg.sv @@
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int LenBits   = 32;
    localparam int MaxDigits = 8;
    localparam int DigitBits = 4;
    localparam int CfgBits   = 32;

    localparam logic [7:0] ChrCr = 8'h0D;
    localparam logic [7:0] ChrLf = 8'h0A;

    localparam logic CfgChunkedMode = 1'b0;
    localparam logic CfgBodyLength  = 1'b1;

    typedef logic [LenBits-1:0] t_len;

    typedef enum logic [4:0] {
        PhSize  = 5'b00001,
        PhData  = 5'b00010,
        PhSkip1 = 5'b00100,
        PhSkip2 = 5'b01000,
        PhDone  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic done;
        logic err;
    } t_status;

    // bit 4: is a hex digit, bits 3:0: digit value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage

@@ sv/hbd_if.sv @@
`timescale 1ns / 1ps

interface hbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface hbd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_done;
    logic       size_error;

    modport source (output valid, output payload_byte, output payload_valid,
                    output body_done, output size_error, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input body_done, input size_error, output ready);
endinterface

interface hbd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic                        index;
    logic [hbd_pkg::CfgBits-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/hbd_in_reg.sv @@
`timescale 1ns / 1ps

module hbd_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbd_byte_if.sink    i_stream,
    hbd_byte_if.source  o_mid
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    assign i_stream.ready    = !r_valid || o_mid.ready;
    assign o_mid.valid       = r_valid;
    assign o_mid.stream_byte = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_stream.ready) begin
            n_valid = i_stream.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stream.valid && i_stream.ready) begin
            r_byte <= i_stream.stream_byte;
        end
    end

endmodule

@@ sv/hbd_core.sv @@
`timescale 1ns / 1ps

module hbd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hbd_byte_if.sink          i_mid,
    hbd_cfg_if.sink           i_cfg,
    hbd_res_if.source         o_res,
    output hbd_pkg::t_status  o_status
);

    logic                                r_chunked;
    logic [hbd_pkg::CfgBits-1:0]         r_body_length;
    hbd_pkg::t_phase                     r_phase,   n_phase;
    hbd_pkg::t_len                       r_chunk,   n_chunk;
    hbd_pkg::t_len                       r_taken,   n_taken;
    logic [hbd_pkg::DigitBits-1:0]       r_digits,  n_digits;
    logic                                r_stopped, n_stopped;
    logic                                r_saw_cr,  n_saw_cr;
    logic                                r_err,     n_err;

    logic          fire;
    logic          pass;
    logic [4:0]    hex;
    logic [63:0]   len_ext;
    hbd_pkg::t_len limit;
    hbd_pkg::t_len taken_inc;
    hbd_pkg::t_len taken_sel;
    hbd_pkg::t_len chunk_dec;
    logic [7:0]    b;

    assign i_cfg.ready = 1'b1;
    assign i_mid.ready = o_res.ready;
    assign o_res.valid = i_mid.valid;
    assign fire        = i_mid.valid && o_res.ready;
    assign b           = i_mid.stream_byte;
    assign hex         = hbd_pkg::hex_decode(b);

    // clip the configured length to the counter range
    assign len_ext   = 64'(r_body_length);
    assign limit     = (|(len_ext >> hbd_pkg::LenBits)) ? '1
                                                        : hbd_pkg::t_len'(r_body_length);
    assign taken_inc = r_taken + 1'b1;
    assign taken_sel = (r_taken < limit) ? taken_inc : r_taken;
    assign chunk_dec = (r_chunk != '0) ? r_chunk - 1'b1 : r_chunk;

    always_comb begin
        n_phase   = r_phase;
        n_chunk   = r_chunk;
        n_taken   = r_taken;
        n_digits  = r_digits;
        n_stopped = r_stopped;
        n_saw_cr  = r_saw_cr;
        n_err     = r_err;
        pass      = 1'b0;
        if (fire && r_phase != hbd_pkg::PhDone) begin
            if (r_chunked) begin
                case (r_phase)
                    hbd_pkg::PhSize: begin
                        if (r_saw_cr && b == hbd_pkg::ChrLf) begin
                            n_phase   = (r_chunk == '0) ? hbd_pkg::PhDone : hbd_pkg::PhData;
                            n_digits  = '0;
                            n_stopped = 1'b0;
                            n_saw_cr  = 1'b0;
                        end else begin
                            n_saw_cr = (b == hbd_pkg::ChrCr);
                            if (!r_stopped) begin
                                if (!hex[4]) begin
                                    n_stopped = 1'b1;
                                end else if (r_digits >= hbd_pkg::DigitBits'(hbd_pkg::MaxDigits))
                                begin
                                    n_err   = 1'b1;
                                    n_chunk = '1;
                                end else begin
                                    n_digits = r_digits + 1'b1;
                                    if (|r_chunk[hbd_pkg::LenBits-1 -: 4]) begin
                                        n_chunk = '1;
                                    end else begin
                                        n_chunk = {r_chunk[hbd_pkg::LenBits-5:0], hex[3:0]};
                                    end
                                end
                            end
                        end
                    end
                    hbd_pkg::PhData: begin
                        pass    = 1'b1;
                        n_chunk = chunk_dec;
                        if (chunk_dec == '0) begin
                            n_phase = hbd_pkg::PhSkip1;
                        end
                    end
                    hbd_pkg::PhSkip1: begin
                        n_phase = hbd_pkg::PhSkip2;
                    end
                    hbd_pkg::PhSkip2: begin
                        n_phase   = hbd_pkg::PhSize;
                        n_chunk   = '0;
                        n_digits  = '0;
                        n_stopped = 1'b0;
                        n_saw_cr  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (r_body_length != '0) begin
                pass    = (r_taken < limit);
                n_taken = taken_sel;
                if (taken_sel >= limit) begin
                    n_phase = hbd_pkg::PhDone;
                end
            end else begin
                pass = 1'b1;
            end
        end
    end

    assign o_res.payload_byte  = pass ? b : 8'h00;
    assign o_res.payload_valid = pass;
    assign o_res.body_done     = (n_phase == hbd_pkg::PhDone);
    assign o_res.size_error    = n_err;

    assign o_status.done = (r_phase == hbd_pkg::PhDone);
    assign o_status.err  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked     <= 1'b0;
            r_body_length <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                hbd_pkg::CfgChunkedMode: r_chunked     <= i_cfg.data[0];
                hbd_pkg::CfgBodyLength:  r_body_length <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hbd_pkg::PhSize;
            r_chunk   <= '0;
            r_taken   <= '0;
            r_digits  <= '0;
            r_stopped <= 1'b0;
            r_saw_cr  <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_chunk   <= n_chunk;
            r_taken   <= n_taken;
            r_digits  <= n_digits;
            r_stopped <= n_stopped;
            r_saw_cr  <= n_saw_cr;
            r_err     <= n_err;
        end
    end

endmodule

@@ sv/hbd_out_reg.sv @@
`timescale 1ns / 1ps

module hbd_out_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbd_res_if.sink     i_res,
    hbd_res_if.source   o_payload
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_payload_byte;
    logic       r_payload_valid;
    logic       r_body_done;
    logic       r_size_error;

    assign i_res.ready             = !r_valid || o_payload.ready;
    assign o_payload.valid         = r_valid;
    assign o_payload.payload_byte  = r_payload_byte;
    assign o_payload.payload_valid = r_payload_valid;
    assign o_payload.body_done     = r_body_done;
    assign o_payload.size_error    = r_size_error;

    always_comb begin
        n_valid = r_valid;
        if (i_res.ready) begin
            n_valid = i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid && i_res.ready) begin
            r_payload_byte  <= i_res.payload_byte;
            r_payload_valid <= i_res.payload_valid;
            r_body_done     <= i_res.body_done;
            r_size_error    <= i_res.size_error;
        end
    end

endmodule

@@ sv/http_body_deframer.sv @@
`timescale 1ns / 1ps
// http body deframer: strips chunked framing or applies a body length, 0 for none
// i_stream: raw body bytes after the headers, valid/ready handshake
// o_payload: one result per input item: payload_byte with payload_valid,
//   plus sticky body_done and size_error flags
// i_cfg: register writes, index 0 chunked_mode, index 1 body_length,
//   always ready; write only while no item is in flight
// path: an item taken passes the input register, then the decoder, and its
//   result the result register; the decoder state updates in one pass
// throughput: one item per cycle while o_payload is not held
// stall: while o_payload is held, the result register and the input
//   register fill and i_stream.ready drops; no item is lost or repeated
// reset: synchronous active low; clears both registers' valid flags, the decoder
//   state (size line phase, counters, error flag) and the configuration to zero
// once the body has ended, later items still give one result each, with
//   payload_valid low, until reset
`include "http_body_deframer_assert.svh"

module http_body_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbd_byte_if.sink    i_stream,
    hbd_cfg_if.sink     i_cfg,
    hbd_res_if.source   o_payload
);

    hbd_byte_if       mid_byte ();
    hbd_res_if        mid_res ();
    hbd_pkg::t_status status;

    hbd_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stream (i_stream),
        .o_mid    (mid_byte)
    );

    hbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mid    (mid_byte),
        .i_cfg    (i_cfg),
        .o_res    (mid_res),
        .o_status (status)
    );

    hbd_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (mid_res),
        .o_payload (o_payload)
    );

    `HBD_ASSERT(a_done_sticky, status.done |=> status.done)
    `HBD_ASSERT(a_err_sticky, status.err |=> status.err)
    `HBD_ASSERT(a_no_pass_after_done, mid_res.valid && status.done |-> !mid_res.payload_valid)
    `HBD_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_payload.valid)

endmodule
